// File: src/bfa_pkg.sv
package bfa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam int ENTRY_BITS = 2 * SIZE_BITS;

  localparam int STATUS_W = 2;
  localparam int INDEX_W = 4;
  localparam int SIZE_W = 16;

  localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PLACED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAITING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] S_IDLE = 4'd0;
  localparam logic [STEP_BITS-1:0] S_DISPATCH = 4'd1;
  localparam logic [STEP_BITS-1:0] S_LOAD_CHK = 4'd2;
  localparam logic [STEP_BITS-1:0] S_LOAD_WR = 4'd3;
  localparam logic [STEP_BITS-1:0] S_REQ_CHK = 4'd4;
  localparam logic [STEP_BITS-1:0] S_SCAN = 4'd5;
  localparam logic [STEP_BITS-1:0] S_PICK = 4'd6;
  localparam logic [STEP_BITS-1:0] S_PLACE = 4'd7;
  localparam logic [STEP_BITS-1:0] S_WAIT = 4'd8;
  localparam logic [STEP_BITS-1:0] S_FULL = 4'd9;
  localparam logic [STEP_BITS-1:0] S_EMIT = 4'd10;

  localparam int COND_BITS = 3;
  localparam logic [COND_BITS-1:0] C_ALWAYS = 3'd0;
  localparam logic [COND_BITS-1:0] C_IN_BEAT = 3'd1;
  localparam logic [COND_BITS-1:0] C_OP_REQ = 3'd2;
  localparam logic [COND_BITS-1:0] C_FULL = 3'd3;
  localparam logic [COND_BITS-1:0] C_EMPTY = 3'd4;
  localparam logic [COND_BITS-1:0] C_SCAN_DONE = 3'd5;
  localparam logic [COND_BITS-1:0] C_FOUND = 3'd6;
  localparam logic [COND_BITS-1:0] C_OUT_FREE = 3'd7;

  localparam int RES_BITS = 3;
  localparam logic [RES_BITS-1:0] RES_NONE = 3'd0;
  localparam logic [RES_BITS-1:0] RES_LOAD = 3'd1;
  localparam logic [RES_BITS-1:0] RES_PLACE = 3'd2;
  localparam logic [RES_BITS-1:0] RES_WAIT = 3'd3;
  localparam logic [RES_BITS-1:0] RES_FULL = 3'd4;

  typedef struct packed {
    logic [COND_BITS-1:0] cond;
    logic [STEP_BITS-1:0] jmp_true;
    logic [STEP_BITS-1:0] jmp_false;
    logic in_ready;
    logic scan_clr;
    logic scan_run;
    logic pick_rd;
    logic load_wr;
    logic place_wr;
    logic [RES_BITS-1:0] res_sel;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic in_beat;
    logic op_req;
    logic full;
    logic empty;
    logic scan_done;
    logic found;
    logic out_free;
  } flags_t;

  function automatic ctrl_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      S_IDLE: begin
        w.cond = C_IN_BEAT;
        w.jmp_true = S_DISPATCH;
        w.jmp_false = S_IDLE;
        w.in_ready = 1'b1;
        w.scan_clr = 1'b1;
      end
      S_DISPATCH: begin
        w.cond = C_OP_REQ;
        w.jmp_true = S_REQ_CHK;
        w.jmp_false = S_LOAD_CHK;
      end
      S_LOAD_CHK: begin
        w.cond = C_FULL;
        w.jmp_true = S_FULL;
        w.jmp_false = S_LOAD_WR;
      end
      S_LOAD_WR: begin
        w.cond = C_ALWAYS;
        w.jmp_true = S_EMIT;
        w.jmp_false = S_EMIT;
        w.load_wr = 1'b1;
        w.res_sel = RES_LOAD;
      end
      S_REQ_CHK: begin
        w.cond = C_EMPTY;
        w.jmp_true = S_WAIT;
        w.jmp_false = S_SCAN;
      end
      S_SCAN: begin
        w.cond = C_SCAN_DONE;
        w.jmp_true = S_PICK;
        w.jmp_false = S_SCAN;
        w.scan_run = 1'b1;
      end
      S_PICK: begin
        w.cond = C_FOUND;
        w.jmp_true = S_PLACE;
        w.jmp_false = S_WAIT;
        w.pick_rd = 1'b1;
      end
      S_PLACE: begin
        w.cond = C_ALWAYS;
        w.jmp_true = S_EMIT;
        w.jmp_false = S_EMIT;
        w.place_wr = 1'b1;
        w.res_sel = RES_PLACE;
      end
      S_WAIT: begin
        w.cond = C_ALWAYS;
        w.jmp_true = S_EMIT;
        w.jmp_false = S_EMIT;
        w.res_sel = RES_WAIT;
      end
      S_FULL: begin
        w.cond = C_ALWAYS;
        w.jmp_true = S_EMIT;
        w.jmp_false = S_EMIT;
        w.res_sel = RES_FULL;
      end
      S_EMIT: begin
        w.cond = C_OUT_FREE;
        w.jmp_true = S_IDLE;
        w.jmp_false = S_EMIT;
        w.emit = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.jmp_true = S_IDLE;
        w.jmp_false = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/best_fit_block_allocator.sv
// Channel  Handshake              Beat contents
// req      req_valid / req_stall  op, size
// rsp      rsp_valid / rsp_stall  status, block_index, original_size, remaining_size
//
// A load is dispatched, checked for a full table and written; a request is dispatched, checked
// for an empty table, then scans one entry per cycle, picks the best fit and places it or waits.
// A result waits in the output register, and the next request beat is taken meanwhile.
// Reset empties the table at once; no clearing pass is needed.
// A finished result holds the sequencer in its last step while an earlier one is stalled.
module best_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          op,
  input  logic [bfa_pkg::SIZE_W-1:0]    size,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bfa_pkg::STATUS_W-1:0]  status,
  output logic [bfa_pkg::INDEX_W-1:0]   block_index,
  output logic [bfa_pkg::SIZE_W-1:0]    original_size,
  output logic [bfa_pkg::SIZE_W-1:0]    remaining_size
);
  import bfa_pkg::*;

  ctrl_t  cw;
  flags_t flags;

  bfa_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  bfa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cw             (cw),
    .flags          (flags),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .op             (op),
    .size           (size),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .block_index    (block_index),
    .original_size  (original_size),
    .remaining_size (remaining_size)
  );

endmodule

// File: src/bfa_ram.sv
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bfa_seq.sv
module bfa_seq (
  input  logic            clk,
  input  logic            rst,
  input  bfa_pkg::flags_t flags,
  output bfa_pkg::ctrl_t  cw
);
  import bfa_pkg::*;

  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  logic                 taken;

  assign cw = ucode(step);

  always_comb begin
    case (cw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_IN_BEAT:   taken = flags.in_beat;
      C_OP_REQ:    taken = flags.op_req;
      C_FULL:      taken = flags.full;
      C_EMPTY:     taken = flags.empty;
      C_SCAN_DONE: taken = flags.scan_done;
      C_FOUND:     taken = flags.found;
      C_OUT_FREE:  taken = flags.out_free;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? cw.jmp_true : cw.jmp_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: src/bfa_dp.sv
module bfa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bfa_pkg::ctrl_t                cw,
  output bfa_pkg::flags_t               flags,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          op,
  input  logic [bfa_pkg::SIZE_W-1:0]    size,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bfa_pkg::STATUS_W-1:0]  status,
  output logic [bfa_pkg::INDEX_W-1:0]   block_index,
  output logic [bfa_pkg::SIZE_W-1:0]    original_size,
  output logic [bfa_pkg::SIZE_W-1:0]    remaining_size
);
  import bfa_pkg::*;

  logic                  op_q;
  logic [SIZE_BITS-1:0]  size_q;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   ptr;
  logic                  lag_valid;
  logic [IDX_BITS-1:0]   lag_idx;
  logic                  found;
  logic [IDX_BITS-1:0]   best;
  logic [SIZE_BITS-1:0]  best_rem;
  logic [STATUS_W-1:0]   res_status;
  logic [IDX_BITS-1:0]   res_idx;
  logic [SIZE_BITS-1:0]  res_orig;
  logic [SIZE_BITS-1:0]  res_rem;

  logic                  in_beat;
  logic                  issue;
  logic                  full;
  logic [SIZE_BITS-1:0]  rd_rem;
  logic [SIZE_BITS-1:0]  rd_orig;
  logic [SIZE_BITS-1:0]  rem_new;
  logic                  better;
  logic                  ram_we;
  logic [IDX_BITS-1:0]   ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [IDX_BITS-1:0]   ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;

  assign req_stall = !cw.in_ready;
  assign in_beat = req_valid && cw.in_ready;
  assign full = (count == CNT_BITS'(NUM_BLOCKS));
  assign issue = (ptr < count);

  assign rd_rem = ram_rdata[SIZE_BITS-1:0];
  assign rd_orig = ram_rdata[ENTRY_BITS-1:SIZE_BITS];
  assign rem_new = rd_rem - size_q;
  assign better = lag_valid && (rd_rem >= size_q) && (!found || (rd_rem < best_rem));

  assign ram_we = cw.load_wr || cw.place_wr;
  assign ram_waddr = cw.load_wr ? count[IDX_BITS-1:0] : best;
  assign ram_wdata = cw.load_wr ? {size_q, size_q} : {rd_orig, rem_new};
  assign ram_raddr = cw.pick_rd ? best : ptr[IDX_BITS-1:0];

  bfa_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    flags.in_beat = in_beat;
    flags.op_req = op_q;
    flags.full = full;
    flags.empty = (count == '0);
    flags.scan_done = lag_valid && (CNT_BITS'(lag_idx) == (count - CNT_BITS'(1)));
    flags.found = found;
    flags.out_free = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_q <= op;
      size_q <= SIZE_BITS'(size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cw.load_wr) begin
      count <= count + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      lag_valid <= 1'b0;
      found <= 1'b0;
    end else if (cw.scan_clr) begin
      ptr <= '0;
      lag_valid <= 1'b0;
      found <= 1'b0;
    end else if (cw.scan_run) begin
      lag_valid <= issue;
      if (issue) begin
        ptr <= ptr + CNT_BITS'(1);
      end
      if (better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.scan_run) begin
      lag_idx <= ptr[IDX_BITS-1:0];
      if (better) begin
        best <= lag_idx;
        best_rem <= rd_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.res_sel)
      RES_LOAD: begin
        res_status <= ST_LOADED;
        res_idx <= count[IDX_BITS-1:0];
        res_orig <= size_q;
        res_rem <= size_q;
      end
      RES_PLACE: begin
        res_status <= ST_PLACED;
        res_idx <= best;
        res_orig <= rd_orig;
        res_rem <= rem_new;
      end
      RES_WAIT: begin
        res_status <= ST_WAITING;
        res_idx <= '0;
        res_orig <= '0;
        res_rem <= '0;
      end
      RES_FULL: begin
        res_status <= ST_FULL;
        res_idx <= '0;
        res_orig <= '0;
        res_rem <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cw.emit && flags.out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && flags.out_free) begin
      status <= res_status;
      block_index <= INDEX_W'(res_idx);
      original_size <= SIZE_W'(res_orig);
      remaining_size <= SIZE_W'(res_rem);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(NUM_BLOCKS))
    else $error("block count exceeds table depth");

  a_load_not_full: assert property (@(posedge clk) disable iff (rst)
    cw.load_wr |-> !full)
    else $error("block written into a full table");

  a_place_found: assert property (@(posedge clk) disable iff (rst)
    cw.place_wr |-> found)
    else $error("job placed without a fitting block");

  a_best_fits: assert property (@(posedge clk) disable iff (rst)
    (found && !cw.scan_clr) |-> (best_rem >= size_q))
    else $error("chosen block is smaller than the job");

endmodule
